[src/psc_pkg.sv]
// Shared types, widths and constants for the PID speed controller.
// No dependencies; imported by every module of the block.
package psc_pkg;

  // Parameter defaults
  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int INTEG_WIDTH_DEF    = 32;

  // Fixed formats
  localparam int INTEG_FRAC  = 8;   // integrator fraction bits
  localparam int INTEG_MAX_W = 48;  // widest integrator supported
  localparam int CHUNK_W     = 24;  // integrator split for the multiplier
  localparam int MUL_A_W     = 17;  // gain operand, signed
  localparam int MUL_B_W     = 25;  // data operand, signed
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W       = 66;  // exact drive sum
  localparam int BACK_W      = 50;  // back-calculation term

  localparam logic [7:0] DUTY_MAX = 8'd255;

  // Register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP_GAIN = 3'd4;

  // Register reset values
  localparam logic [7:0]  SETPOINT_RST    = 8'd60;
  localparam logic [15:0] PROP_GAIN_RST   = 16'd256;
  localparam logic [15:0] INTEG_GAIN_RST  = 16'd128;
  localparam logic [15:0] DERIV_GAIN_RST  = 16'd1024;
  localparam logic [15:0] WINDUP_GAIN_RST = 16'd256;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INTEG,
    S_MUL_D,
    S_MUL_IL,
    S_MUL_IH,
    S_ACC,
    S_RAW,
    S_BACK,
    S_BDIV,
    S_WB
  } state_t;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MSEL_NONE,
    MSEL_P,
    MSEL_D,
    MSEL_IL,
    MSEL_IH,
    MSEL_B
  } mul_sel_t;

  // Accumulator operation on the registered product
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD8,
    ACC_ADD8,
    ACC_ADD0,
    ACC_ADD24
  } acc_op_t;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    logic     integ_add;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     raw_en;
    logic     back_en;
    logic     wb_go;
  } ctl_t;

endpackage

[src/psc_mul.sv]
// Shared signed multiplier with registered product.
// Depends on psc_pkg for operand widths.
module psc_mul
  import psc_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  logic signed [MUL_P_W-1:0] p_r;

  // One product per enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

[src/psc_seq.sv]
// Sequencer that steps one control tick through the shared multiplier.
// Depends on psc_pkg for state and control types.
module psc_seq
  import psc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic out_free,
  output logic in_ready,
  output ctl_t ctl
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and controls
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    ctl.integ_add = 1'b0;
    ctl.mul_en    = 1'b0;
    ctl.mul_sel   = MSEL_NONE;
    ctl.acc_op    = ACC_HOLD;
    ctl.raw_en    = 1'b0;
    ctl.back_en   = 1'b0;
    ctl.wb_go     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) state_nxt = S_INTEG;
      end
      S_INTEG: begin
        ctl.integ_add = 1'b1;
        ctl.mul_en    = 1'b1;
        ctl.mul_sel   = MSEL_P;
        state_nxt     = S_MUL_D;
      end
      S_MUL_D: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MSEL_D;
        ctl.acc_op  = ACC_LOAD8;
        state_nxt   = S_MUL_IL;
      end
      S_MUL_IL: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MSEL_IL;
        ctl.acc_op  = ACC_ADD8;
        state_nxt   = S_MUL_IH;
      end
      S_MUL_IH: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MSEL_IH;
        ctl.acc_op  = ACC_ADD0;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        ctl.acc_op = ACC_ADD24;
        state_nxt  = S_RAW;
      end
      S_RAW: begin
        ctl.raw_en = 1'b1;
        state_nxt  = S_BACK;
      end
      S_BACK: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MSEL_B;
        state_nxt   = S_BDIV;
      end
      S_BDIV: begin
        ctl.back_en = 1'b1;
        state_nxt   = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          ctl.wb_go = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[src/pid_speed_controller_antiwindup.sv]
// Top level of the PID speed controller with back-calculation anti-windup.
// Depends on psc_pkg, psc_mul and psc_seq.
//
// One beat on the input channel is one control tick carrying the measured
// speed; it yields one output beat with the duty (raw drive clamped to
// 0..255) and the raw drive (truncated toward zero, clamped to 16 bits).
// Ticks do not overlap: ready falls on acceptance and rises again after the
// integrator write-back, which waits until the previous result is taken.
// All five products (Kp*e, Kd*de, two halves of Ki*integrator,
// Kb*(raw-duty)) go through a single 17x25 multiplier one after another,
// with the drive normalize between the Ki and Kb products and the
// integrator write-back at the end. The output register holds a finished
// result while the next tick is already being worked on; if that result is
// still not taken when the next one finishes, the block waits.
// Configuration writes take effect at once and should be made while idle.
module pid_speed_controller_antiwindup
  import psc_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int INTEG_WIDTH    = INTEG_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_measured_speed,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_duty,
  output logic signed [15:0]    out_raw_drive
);

  localparam int GF = GAIN_FRAC_BITS;
  localparam int IW = INTEG_WIDTH;
  localparam int SH = GF + INTEG_FRAC;
  localparam int DW = ((IW > BACK_W) ? IW : BACK_W) + 1;

  localparam logic signed [IW-1:0]     I_MAX  = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0]     I_MIN  = {1'b1, {(IW-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]  RND    = (ACC_W'(1) <<< SH) - ACC_W'(1);
  localparam logic signed [BACK_W-1:0] BRND   = (BACK_W'(1) <<< GF) - BACK_W'(1);
  localparam logic signed [ACC_W-1:0]  RAW_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0]  RAW_LO = ACC_W'(-32768);

  // Configuration registers
  logic [7:0]  setpoint_r;
  logic [15:0] prop_gain_r, integ_gain_r, deriv_gain_r, windup_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r    <= SETPOINT_RST;
      prop_gain_r   <= PROP_GAIN_RST;
      integ_gain_r  <= INTEG_GAIN_RST;
      deriv_gain_r  <= DERIV_GAIN_RST;
      windup_gain_r <= WINDUP_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETPOINT:    setpoint_r    <= cfg_data[7:0];
        REG_PROP_GAIN:   prop_gain_r   <= cfg_data;
        REG_INTEG_GAIN:  integ_gain_r  <= cfg_data;
        REG_DERIV_GAIN:  deriv_gain_r  <= cfg_data;
        REG_WINDUP_GAIN: windup_gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  ctl_t ctl;
  logic in_fire, out_free;
  logic out_valid_r;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  psc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // Error, derivative and controller state
  logic signed [8:0]    err_r, err_nxt, last_err_r;
  logic signed [9:0]    deriv_r;
  logic signed [IW-1:0] integ_r;
  logic signed [16:0]   err_sh;
  logic signed [IW:0]   isum;
  logic                 isum_ovf;
  logic signed [IW-1:0] isum_sat;
  logic signed [BACK_W-1:0] back_r;
  logic signed [DW-1:0] idiff;
  logic [DW-IW:0]       idiff_top;
  logic                 idiff_ovf;
  logic signed [IW-1:0] idiff_sat;

  assign err_nxt = $signed({1'b0, setpoint_r}) - $signed({1'b0, in_measured_speed});
  assign err_sh  = {err_r, 8'd0};

  // integrator plus error in Q.8, saturated
  assign isum     = (IW+1)'(integ_r) + (IW+1)'(err_sh);
  assign isum_ovf = isum[IW] != isum[IW-1];
  assign isum_sat = isum_ovf ? (isum[IW] ? I_MIN : I_MAX) : isum[IW-1:0];

  // integrator minus back-calculation term, saturated
  assign idiff     = DW'(integ_r) - DW'(back_r);
  assign idiff_top = idiff[DW-1:IW-1];
  assign idiff_ovf = !((&idiff_top) || !(|idiff_top));
  assign idiff_sat = idiff_ovf ? (idiff[DW-1] ? I_MIN : I_MAX) : idiff[IW-1:0];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      integ_r    <= '0;
    end else if (ctl.integ_add) begin
      last_err_r <= err_r;
      integ_r    <= isum_sat;
    end else if (ctl.wb_go) begin
      integ_r    <= idiff_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.integ_add) begin
      deriv_r <= 10'(err_r) - 10'(last_err_r);
    end
  end

  // Multiplier operands
  logic signed [INTEG_MAX_W-1:0] integ_x;
  logic signed [CHUNK_W-1:0]     integ_hi;
  logic signed [15:0]            raw_r;
  logic [7:0]                    duty_r;
  logic signed [16:0]            bdiff;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [MUL_P_W-1:0]     prod;

  assign integ_x  = INTEG_MAX_W'(integ_r);
  assign integ_hi = integ_x[INTEG_MAX_W-1:CHUNK_W];
  assign bdiff    = 17'(raw_r) - 17'($signed({1'b0, duty_r}));

  always_comb begin
    unique case (ctl.mul_sel)
      MSEL_P: begin
        mul_a = $signed({1'b0, prop_gain_r});
        mul_b = MUL_B_W'(err_r);
      end
      MSEL_D: begin
        mul_a = $signed({1'b0, deriv_gain_r});
        mul_b = MUL_B_W'(deriv_r);
      end
      MSEL_IL: begin
        mul_a = $signed({1'b0, integ_gain_r});
        mul_b = $signed({1'b0, integ_x[CHUNK_W-1:0]});
      end
      MSEL_IH: begin
        mul_a = $signed({1'b0, integ_gain_r});
        mul_b = MUL_B_W'(integ_hi);
      end
      MSEL_B: begin
        mul_a = $signed({1'b0, windup_gain_r});
        mul_b = MUL_B_W'(bdiff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  psc_mul u_mul (
    .clk (clk),
    .en  (ctl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Drive accumulator
  logic signed [ACC_W-1:0] acc_r, acc_nxt, prod_x;

  assign prod_x = ACC_W'(prod);

  always_comb begin
    unique case (ctl.acc_op)
      ACC_LOAD8: acc_nxt = prod_x <<< INTEG_FRAC;
      ACC_ADD8:  acc_nxt = acc_r + (prod_x <<< INTEG_FRAC);
      ACC_ADD0:  acc_nxt = acc_r + prod_x;
      ACC_ADD24: acc_nxt = acc_r + (prod_x <<< CHUNK_W);
      default:   acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Raw drive: truncate toward zero, clamp to 16 bits, derive duty
  logic signed [ACC_W-1:0] acc_adj, acc_q;
  logic signed [15:0]      raw_nxt;
  logic [7:0]              duty_nxt;

  assign acc_adj = acc_r + (acc_r[ACC_W-1] ? RND : ACC_W'(0));
  assign acc_q   = acc_adj >>> SH;

  always_comb begin
    if (acc_q > RAW_HI) begin
      raw_nxt = 16'sh7FFF;
    end else if (acc_q < RAW_LO) begin
      raw_nxt = 16'sh8000;
    end else begin
      raw_nxt = acc_q[15:0];
    end
    if (raw_nxt[15]) begin
      duty_nxt = 8'd0;
    end else if (raw_nxt > 16'sd255) begin
      duty_nxt = DUTY_MAX;
    end else begin
      duty_nxt = raw_nxt[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.raw_en) begin
      raw_r  <= raw_nxt;
      duty_r <= duty_nxt;
    end
  end

  // Back-calculation term in Q.8, truncated toward zero
  logic signed [BACK_W-1:0] bv, bv_adj;

  assign bv     = BACK_W'(prod) <<< INTEG_FRAC;
  assign bv_adj = bv + (bv[BACK_W-1] ? BRND : BACK_W'(0));

  always_ff @(posedge clk) begin
    if (ctl.back_en) begin
      back_r <= bv_adj >>> GF;
    end
  end

  // Output register
  logic [7:0]         out_duty_r;
  logic signed [15:0] out_raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.wb_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wb_go) begin
      out_duty_r <= duty_r;
      out_raw_r  <= raw_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_duty      = out_duty_r;
  assign out_raw_drive = out_raw_r;

`ifndef SYNTHESIS
  a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input accepted while a tick is in progress");

  a_wb_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wb_go |=> out_valid)
    else $error("write-back did not present a result");

  a_duty_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_raw_drive[15] |-> out_duty == 8'd0)
    else $error("duty nonzero for negative drive");

  a_duty_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_raw_drive[15] && (out_raw_drive[14:8] != 7'd0)
    |-> out_duty == DUTY_MAX)
    else $error("duty not saturated for large drive");

  a_duty_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_raw_drive[15] && (out_raw_drive[14:8] == 7'd0)
    |-> out_duty == out_raw_drive[7:0])
    else $error("duty differs from in-range drive");
`endif

endmodule
